[hw/rtl/md3vd_pkg.sv]
// ----------------------------------------------------------------------------
// md3vd_pkg
// Shared types and the quarter-wave sine table for the vertex decoder.
// ----------------------------------------------------------------------------
package md3vd_pkg;

    localparam int          SINE_LAST = 64;
    localparam logic [63:0] PI_Q32    = 64'h0000_0003_243F_6A88;
    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;

    typedef logic signed [15:0] s16_t;

    // magnitude/sign form of a Q30 sine or cosine
    typedef struct packed {
        logic        neg;
        logic [30:0] mag;
    } sine_t;

    typedef struct packed {
        s16_t x;
        s16_t y;
        s16_t z;
    } norm_t;

    typedef logic [SINE_LAST:0][30:0] sine_tab_t;

    // sin(k*pi/128) in Q30, Taylor series to x^15, truncating arithmetic
    function automatic logic [30:0] quarter_sine(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        if (k >= SINE_LAST)
        begin
            return ONE_Q30;
        end
        x    = (64'(k) * PI_Q32 + 64'd256) >> 9;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - longint'(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        if (sum > longint'(ONE_Q30))
        begin
            sum = longint'(ONE_Q30);
        end
        return sum[30:0];
    endfunction

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t tab;
        for (int unsigned k = 0; k <= SINE_LAST; k++)
        begin
            tab[k] = quarter_sine(k);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

[hw/rtl/md3vd_normal.sv]
// ----------------------------------------------------------------------------
// md3vd_normal
// Expands a lat/long packed normal into a unit vector, one per cycle.
// ----------------------------------------------------------------------------
module md3vd_normal #(
    parameter int NORM_FRAC_BITS = 14
) (
    input  logic [15:0]       normal_code,
    output md3vd_pkg::norm_t  norm
);
    import md3vd_pkg::*;

    localparam int SH = 60 - NORM_FRAC_BITS;

    // quarter-wave symmetry on the 65-entry table
    function automatic sine_t sine_lookup(input logic [7:0] i);
        logic [6:0] j;
        logic [6:0] idx;
        sine_t      r;
        j     = i[6:0];
        idx   = (j <= 7'd64) ? j : 7'(8'd128 - {1'b0, j});
        r.mag = SINE_TAB[idx];
        r.neg = i[7];
        return r;
    endfunction

    // Q60 magnitude to NORM_FRAC_BITS, half away from zero, then saturate
    function automatic s16_t round_sat(input logic [61:0] mag, input logic neg);
        logic [62:0] sum;
        logic [62:0] r;
        s16_t        res;
        sum = {1'b0, mag} + (63'd1 << (SH - 1));
        r   = sum >> SH;
        if (!neg)
        begin
            res = (r > 63'd32767) ? 16'sh7FFF : s16_t'(r[15:0]);
        end
        else
        begin
            res = (r > 63'd32768) ? 16'sh8000 : s16_t'(16'd0 - r[15:0]);
        end
        return res;
    endfunction

    sine_t       lat_sin;
    sine_t       lat_cos;
    sine_t       lon_sin;
    sine_t       lon_cos;
    logic [61:0] prod_x;
    logic [61:0] prod_y;
    logic [61:0] mag_z;

    always_comb
    begin
        lat_sin = sine_lookup(normal_code[15:8]);
        lat_cos = sine_lookup(8'(normal_code[15:8] + 8'd64));
        lon_sin = sine_lookup(normal_code[7:0]);
        lon_cos = sine_lookup(8'(normal_code[7:0] + 8'd64));
        prod_x  = 62'(lat_cos.mag) * 62'(lon_sin.mag);
        prod_y  = 62'(lat_sin.mag) * 62'(lon_sin.mag);
        mag_z   = {1'b0, lon_cos.mag, 30'd0};
        norm.x  = round_sat(prod_x, lat_cos.neg ^ lon_sin.neg);
        norm.y  = round_sat(prod_y, lat_sin.neg ^ lon_sin.neg);
        norm.z  = round_sat(mag_z, lon_cos.neg);
    end

endmodule

[hw/rtl/md3_vertex_decode.sv]
// ----------------------------------------------------------------------------
// md3_vertex_decode
// Compressed vertex decoder: scaled position, lat/long normal, running box.
// ----------------------------------------------------------------------------
//  channel | signals                                   | transfer
//  --------+-------------------------------------------+----------------------
//  input   | in_valid/in_ready, new_model, pos_x/y/z,  | valid & ready at clk
//          | normal_code                               |
//  output  | out_valid/out_ready, out_x/y/z, norm_x/y/z,| valid & ready at clk
//          | box_min_x/y/z, box_max_x/y/z              |
//
//  One transaction per cycle sustained while out_ready allows; each passes the
//  input register, then the result register. The normal path (table lookup,
//  31x31 multiply, round) sets the critical path between the two registers.
//  Reset empties the box (min 32767, max -32768) and clears both valid flags.
//  A stall on out_ready holds the result; in_ready stays high while the input
//  register is empty or moving on in the same cycle.
// ----------------------------------------------------------------------------
module md3_vertex_decode #(
    parameter int POS_FRAC_BITS  = 6,
    parameter int NORM_FRAC_BITS = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                new_model,
    input  md3vd_pkg::s16_t     pos_x,
    input  md3vd_pkg::s16_t     pos_y,
    input  md3vd_pkg::s16_t     pos_z,
    input  logic [15:0]         normal_code,
    output logic                out_valid,
    input  logic                out_ready,
    output md3vd_pkg::s16_t     out_x,
    output md3vd_pkg::s16_t     out_y,
    output md3vd_pkg::s16_t     out_z,
    output md3vd_pkg::s16_t     norm_x,
    output md3vd_pkg::s16_t     norm_y,
    output md3vd_pkg::s16_t     norm_z,
    output md3vd_pkg::s16_t     box_min_x,
    output md3vd_pkg::s16_t     box_min_y,
    output md3vd_pkg::s16_t     box_min_z,
    output md3vd_pkg::s16_t     box_max_x,
    output md3vd_pkg::s16_t     box_max_y,
    output md3vd_pkg::s16_t     box_max_z
);
    import md3vd_pkg::*;

    // input is in 1/64 units: shift left for extra fraction bits, arithmetic
    // shift right (floor) for fewer
    localparam int POS_UP = (POS_FRAC_BITS >= 6) ? POS_FRAC_BITS - 6 : 0;
    localparam int POS_DN = (POS_FRAC_BITS < 6) ? 6 - POS_FRAC_BITS : 0;

    localparam s16_t BOX_EMPTY_MIN = 16'sh7FFF;
    localparam s16_t BOX_EMPTY_MAX = 16'sh8000;

    // input register
    logic        s1_valid_reg;
    logic        s1_new_reg;
    s16_t        s1_pos_reg [3];
    logic [15:0] s1_code_reg;

    // result register and box state
    logic        out_valid_reg;
    s16_t        pos_reg [3];
    norm_t       norm_reg;
    s16_t        min_reg [3];
    s16_t        max_reg [3];

    s16_t        pos_next [3];
    s16_t        min_next [3];
    s16_t        max_next [3];
    norm_t       norm_next;

    logic        out_adv;
    logic        s1_adv;
    logic        in_fire;

    assign out_adv  = !out_valid_reg || out_ready;
    assign s1_adv   = s1_valid_reg && out_adv;
    assign in_ready = !s1_valid_reg || out_adv;
    assign in_fire  = in_valid && in_ready;

    md3vd_normal #(
        .NORM_FRAC_BITS (NORM_FRAC_BITS)
    ) u_normal (
        .normal_code (s1_code_reg),
        .norm        (norm_next)
    );

    // position scaling and box update
    always_comb
    begin
        logic signed [31:0] wide;
        logic signed [31:0] scaled;
        s16_t               base_min;
        s16_t               base_max;
        for (int i = 0; i < 3; i++)
        begin
            wide   = 32'(s1_pos_reg[i]);
            scaled = (wide <<< POS_UP) >>> POS_DN;
            if (scaled > 32'sd32767)
            begin
                pos_next[i] = 16'sh7FFF;
            end
            else if (scaled < -32'sd32768)
            begin
                pos_next[i] = 16'sh8000;
            end
            else
            begin
                pos_next[i] = s16_t'(scaled[15:0]);
            end
            base_min    = s1_new_reg ? BOX_EMPTY_MIN : min_reg[i];
            base_max    = s1_new_reg ? BOX_EMPTY_MAX : max_reg[i];
            min_next[i] = (pos_next[i] < base_min) ? pos_next[i] : base_min;
            max_next[i] = (pos_next[i] > base_max) ? pos_next[i] : base_max;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                min_reg[i] <= BOX_EMPTY_MIN;
                max_reg[i] <= BOX_EMPTY_MAX;
            end
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_adv)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    min_reg[i] <= min_next[i];
                    max_reg[i] <= max_next[i];
                end
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_new_reg    <= new_model;
            s1_pos_reg[0] <= pos_x;
            s1_pos_reg[1] <= pos_y;
            s1_pos_reg[2] <= pos_z;
            s1_code_reg   <= normal_code;
        end
        if (s1_adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= pos_next[i];
            end
            norm_reg <= norm_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = pos_reg[0];
    assign out_y     = pos_reg[1];
    assign out_z     = pos_reg[2];
    assign norm_x    = norm_reg.x;
    assign norm_y    = norm_reg.y;
    assign norm_z    = norm_reg.z;
    // box state only moves together with the result register
    assign box_min_x = min_reg[0];
    assign box_min_y = min_reg[1];
    assign box_min_z = min_reg[2];
    assign box_max_x = max_reg[0];
    assign box_max_y = max_reg[1];
    assign box_max_z = max_reg[2];

endmodule

[dv/md3_vertex_decode_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// md3_vertex_decode_tb
// Self-checking bench for the vertex decoder. Vertices go in through the
// valid/ready input channel; each decoded vertex (position, lat/long normal
// and running box) is predicted on acceptance and compared field by field
// with the result transaction that comes out, in order.
// ----------------------------------------------------------------------------
module md3_vertex_decode_tb;

    import md3vd_pkg::*;

    // Must match the defaults of the block under test.
    localparam int POS_FRAC_BITS  = 6;
    localparam int NORM_FRAC_BITS = 14;

    // Q32 pi and Q30 one for the sine series.
    localparam logic [63:0] PI_FIX_Q32 = 64'h0000_0003_243F_6A88;
    localparam longint      UNIT_Q30   = 64'sd1 << 30;

    // Quarter-wave points and the top code of the 256-step angle.
    localparam logic [7:0] ANG_ZERO    = 8'd0;
    localparam logic [7:0] ANG_QUARTER = 8'd64;
    localparam logic [7:0] ANG_HALF    = 8'd128;
    localparam logic [7:0] ANG_3QUART  = 8'd192;
    localparam logic [7:0] ANG_TOP     = 8'd255;

    localparam int NO_ACCEPT_LIMIT = 1000;  // watchdog, cycles without a transaction
    localparam int STALL_CYCLES    = 60;    // the long output hold-off
    localparam int DRAIN_CYCLES    = 8;     // drain margin after the queue empties, leave some slack
    localparam int RANDOM_ITEMS    = 1000;
    localparam int MAX_PRINTS      = 40;

    typedef struct {
        logic        new_model;
        s16_t        pos[3];
        logic [15:0] code;
    } vertex_t;

    typedef struct {
        s16_t pos[3];
        s16_t nrm[3];
        s16_t lo[3];
        s16_t hi[3];
    } decoded_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block I/O
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        new_model = 1'b0;
    s16_t        pos_x = '0;
    s16_t        pos_y = '0;
    s16_t        pos_z = '0;
    logic [15:0] normal_code = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    s16_t        out_x, out_y, out_z;
    s16_t        norm_x, norm_y, norm_z;
    s16_t        box_min_x, box_min_y, box_min_z;
    s16_t        box_max_x, box_max_y, box_max_z;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    md3_vertex_decode #(
        .POS_FRAC_BITS  (POS_FRAC_BITS),
        .NORM_FRAC_BITS (NORM_FRAC_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .new_model   (new_model),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .normal_code (normal_code),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .norm_x      (norm_x),
        .norm_y      (norm_y),
        .norm_z      (norm_z),
        .box_min_x   (box_min_x),
        .box_min_y   (box_min_y),
        .box_min_z   (box_min_z),
        .box_max_x   (box_max_x),
        .box_max_y   (box_max_y),
        .box_max_z   (box_max_z)
    );

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    decoded_t pending_decodes[$];   // predicted vertices, oldest first
    s16_t     box_lo[3];            // predicted running box
    s16_t     box_hi[3];
    int       mismatches   = 0;
    bit       no_gaps      = 1'b0;  // both sides run flat out while set
    bit       hold_request = 1'b0;  // asks the receiver for a long hold-off
    int       hold_left    = 0;
    int       quiet_cycles = 0;
    decoded_t rx_want;

    // ------------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------------
    function automatic s16_t clamp16(longint v);
        if (v > 32767)
        begin
            return 16'sh7FFF;
        end
        if (v < -32768)
        begin
            return 16'sh8000;
        end
        return s16_t'(v);
    endfunction

    // sin(k*pi/128) in Q30 for the first quadrant: odd Taylor terms up to x^15,
    // every product truncated back to Q30, then clamped to [0, 1].
    function automatic longint quarter_wave_q30(int unsigned k);
        logic [63:0] ang;
        logic [63:0] ang_sq;
        logic [63:0] term;
        longint      acc;
        if (k >= 64)
        begin
            return UNIT_Q30;
        end
        ang    = (64'(k) * PI_FIX_Q32 + 64'd256) >> 9;
        ang_sq = (ang * ang) >> 30;
        term   = ang;
        acc    = longint'(ang);
        for (int n = 1; n <= 7; n++)
        begin
            term = (term * ang_sq) >> 30;
            term = term / 64'(4 * n * n + 2 * n);
            if (n % 2 == 1)
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        if (acc > UNIT_Q30)
        begin
            acc = UNIT_Q30;
        end
        return acc;
    endfunction

    // full circle from the quarter wave by symmetry
    function automatic longint sine_q30(logic [7:0] ang);
        logic [6:0]  fold;
        longint      mag;
        fold = ang[6:0];
        mag  = quarter_wave_q30((fold <= 7'd64) ? fold : 128 - fold);
        return ang[7] ? -mag : mag;
    endfunction

    function automatic longint cosine_q30(logic [7:0] ang);
        return sine_q30(ang + ANG_QUARTER);
    endfunction

    // round half away from zero, then saturate
    function automatic s16_t round_away(longint v, int sh);
        bit     neg;
        longint mag;
        neg = v < 0;
        mag = neg ? -v : v;
        mag = (mag + (64'sd1 << (sh - 1))) >>> sh;
        return clamp16(neg ? -mag : mag);
    endfunction

    // packed 1/64 units to POS_FRAC_BITS; floor when narrowing
    function automatic s16_t scale_position(s16_t raw);
        longint p;
        int     up;
        int     dn;
        p  = raw;
        up = (POS_FRAC_BITS >= 6) ? POS_FRAC_BITS - 6 : 0;
        dn = (POS_FRAC_BITS < 6) ? 6 - POS_FRAC_BITS : 0;
        if (POS_FRAC_BITS >= 6)
        begin
            return clamp16(p <<< up);
        end
        return clamp16(p >>> dn);
    endfunction

    function automatic void empty_box();
        for (int i = 0; i < 3; i++)
        begin
            box_lo[i] = 16'sh7FFF;
            box_hi[i] = 16'sh8000;
        end
    endfunction

    // Works out the decoded vertex and moves the running box on.
    function automatic decoded_t decode_vertex(vertex_t v);
        decoded_t d;
        longint   s_lat;
        longint   c_lat;
        longint   s_lon;
        if (v.new_model)
        begin
            empty_box();
        end
        for (int i = 0; i < 3; i++)
        begin
            d.pos[i] = scale_position(v.pos[i]);
            if (d.pos[i] < box_lo[i])
            begin
                box_lo[i] = d.pos[i];
            end
            if (d.pos[i] > box_hi[i])
            begin
                box_hi[i] = d.pos[i];
            end
            d.lo[i] = box_lo[i];
            d.hi[i] = box_hi[i];
        end
        s_lat = sine_q30(v.code[15:8]);
        c_lat = cosine_q30(v.code[15:8]);
        s_lon = sine_q30(v.code[7:0]);
        d.nrm[0] = round_away(c_lat * s_lon, 60 - NORM_FRAC_BITS);
        d.nrm[1] = round_away(s_lat * s_lon, 60 - NORM_FRAC_BITS);
        d.nrm[2] = round_away(cosine_q30(v.code[7:0]), 30 - NORM_FRAC_BITS);
        return d;
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Offers one vertex and returns once it is accepted. in_valid is left high
    // so back-to-back vertices need no gap; an idle gap lowers it first.
    task automatic send_vertex(vertex_t v);
        if (!no_gaps && $urandom_range(99) < 16)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        new_model   <= v.new_model;
        pos_x       <= v.pos[0];
        pos_y       <= v.pos[1];
        pos_z       <= v.pos[2];
        normal_code <= v.code;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        pending_decodes.push_back(decode_vertex(v));
    endtask

    function automatic vertex_t make_vertex(logic nm, int x, int y, int z,
                                            logic [7:0] lat, logic [7:0] lon);
        vertex_t v;
        v.new_model = nm;
        v.pos[0]    = s16_t'(x);
        v.pos[1]    = s16_t'(y);
        v.pos[2]    = s16_t'(z);
        v.code      = {lat, lon};
        return v;
    endfunction

    function automatic logic [7:0] random_angle();
        logic [7:0] special[8];
        special = '{ANG_ZERO, ANG_QUARTER, ANG_HALF, ANG_3QUART, ANG_TOP,
                    8'd63, 8'd65, 8'd127};
        if ($urandom_range(99) < 20)
        begin
            return special[$urandom_range(7)];
        end
        return 8'($urandom);
    endfunction

    function automatic int random_coord(int centre);
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? 32767 : -32768;
            1, 2:    return int'(s16_t'($urandom));
            default: return int'(clamp16(centre + int'($urandom_range(0, 512)) - 256));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Output side: checker and ready generation
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        if (mismatches < MAX_PRINTS)
        begin
            $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        end
        mismatches++;
    endtask

    task automatic check_field(string what, s16_t got, s16_t want);
        if (got !== want)
        begin
            report_mismatch(what, got, want);
        end
    endtask

    // Samples the pre-edge handshake, then chooses the next out_ready.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_decodes.size() == 0)
            begin
                report_mismatch("unexpected result transaction", 1, 0);
            end
            else
            begin
                rx_want = pending_decodes.pop_front();
                check_field("out_x", out_x, rx_want.pos[0]);
                check_field("out_y", out_y, rx_want.pos[1]);
                check_field("out_z", out_z, rx_want.pos[2]);
                check_field("norm_x", norm_x, rx_want.nrm[0]);
                check_field("norm_y", norm_y, rx_want.nrm[1]);
                check_field("norm_z", norm_z, rx_want.nrm[2]);
                check_field("box_min_x", box_min_x, rx_want.lo[0]);
                check_field("box_min_y", box_min_y, rx_want.lo[1]);
                check_field("box_min_z", box_min_z, rx_want.lo[2]);
                check_field("box_max_x", box_max_x, rx_want.hi[0]);
                check_field("box_max_y", box_max_y, rx_want.hi[1]);
                check_field("box_max_z", box_max_z, rx_want.hi[2]);
            end
        end
        // long hold-off is counted here, not in the stimulus thread
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = STALL_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= no_gaps || ($urandom_range(99) >= 16);
        end
    end

    // Watchdog: any transaction on either side restarts the count.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= NO_ACCEPT_LIMIT)
        begin
            $display("%0t watchdog: no transaction for %0d cycles", $time, quiet_cycles);
            $display("FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // After reset the box is empty, so the first vertex must report itself as
    // the box even without new_model.
    task automatic test_box_after_reset();
        send_vertex(make_vertex(1'b0, 100, -200, 300, ANG_ZERO, ANG_ZERO));
        send_vertex(make_vertex(1'b0, -50, 400, 300, ANG_ZERO, ANG_QUARTER));
    endtask

    // Full-scale and sign-boundary positions; the box must reach both ends.
    task automatic test_position_extremes();
        send_vertex(make_vertex(1'b0, 32767, -32768, 0, ANG_QUARTER, ANG_QUARTER));
        send_vertex(make_vertex(1'b0, -32768, 32767, -1, ANG_HALF, ANG_HALF));
        send_vertex(make_vertex(1'b0, 1, -1, 32767, ANG_TOP, ANG_TOP));
        send_vertex(make_vertex(1'b0, 16'h5555, 16'hAAAA, -32768, 8'd1, 8'd1));
    endtask

    // Quadrant boundaries, the exact-one point of the table, the fold on both
    // sides of a quarter turn and the top code.
    task automatic test_normal_angles();
        send_vertex(make_vertex(1'b0, 0, 0, 0, ANG_ZERO, ANG_HALF));
        send_vertex(make_vertex(1'b0, 0, 0, 0, ANG_QUARTER, ANG_QUARTER));
        send_vertex(make_vertex(1'b0, 0, 0, 0, ANG_HALF, ANG_3QUART));
        send_vertex(make_vertex(1'b0, 0, 0, 0, ANG_3QUART, ANG_QUARTER));
        send_vertex(make_vertex(1'b0, 0, 0, 0, 8'd63, 8'd65));
        send_vertex(make_vertex(1'b0, 0, 0, 0, 8'd127, 8'd129));
        send_vertex(make_vertex(1'b0, 0, 0, 0, 8'd32, 8'd224));
        send_vertex(make_vertex(1'b0, 0, 0, 0, ANG_TOP, ANG_ZERO));
    endtask

    // new_model drops the old box and starts from this vertex alone.
    task automatic test_new_model();
        send_vertex(make_vertex(1'b1, 10, 20, 30, 8'd16, 8'd48));
        send_vertex(make_vertex(1'b0, -10, 25, 5, 8'd200, 8'd100));
        send_vertex(make_vertex(1'b1, 7, 7, 7, 8'd90, 8'd170));
        send_vertex(make_vertex(1'b1, -7, -7, -7, 8'd91, 8'd171));
    endtask

    // Receiver stalls for a long stretch while vertices keep coming, so both
    // pipeline registers fill and in_ready must drop.
    task automatic test_output_stall();
        no_gaps      = 1'b1;
        hold_request = 1'b1;
        for (int i = 0; i < 12; i++)
        begin
            send_vertex(make_vertex(i == 0, random_coord(0), random_coord(0),
                                    random_coord(0), random_angle(), random_angle()));
        end
        no_gaps = 1'b0;
    endtask

    // Mostly well-formed models (new_model on the first vertex, positions
    // clustered round a centre) with stray new_model flags as noise. A middle
    // stretch runs with no gaps on either side.
    task automatic test_random_models();
        int      sent;
        int      len;
        int      cx, cy, cz;
        vertex_t v;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            len = $urandom_range(1, 40);
            cx  = int'(s16_t'($urandom));
            cy  = int'(s16_t'($urandom));
            cz  = int'(s16_t'($urandom));
            for (int i = 0; i < len && sent < RANDOM_ITEMS; i++)
            begin
                no_gaps = (sent >= 400) && (sent < 550);
                v = make_vertex(i == 0, random_coord(cx), random_coord(cy),
                                random_coord(cz), random_angle(), random_angle());
                if ($urandom_range(99) < 5)
                begin
                    v.new_model = 1'($urandom_range(1));
                end
                send_vertex(v);
                sent++;
            end
        end
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        empty_box();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_box_after_reset();
        test_position_extremes();
        test_normal_angles();
        test_new_model();
        test_output_stall();
        test_random_models();
        in_valid <= 1'b0;

        // drain, then a few more cycles to catch anything extra
        while (pending_decodes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_decodes.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/md3vd_pkg.sv
hw/rtl/md3vd_normal.sv
hw/rtl/md3_vertex_decode.sv
dv/md3_vertex_decode_tb.sv
